// ===== hdl/ami_pkg.sv =====
// Package for the affine matrix inverse block: shared types and constants.
// No dependencies.
package ami_pkg;
   localparam int PORT_BITS = 32;
   localparam int THRESH_BITS = 32;
   typedef logic [PORT_BITS-1:0] word_type;
endpackage

// ===== hdl/ami_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on ami_pkg.
interface ami_req_if;
   ami_pkg::word_type coef_a, coef_b, coef_c, coef_d, coef_e, coef_f;
   logic valid;
   logic ready;
   modport source (output valid, coef_a, coef_b, coef_c, coef_d, coef_e, coef_f, input ready);
   modport sink (input valid, coef_a, coef_b, coef_c, coef_d, coef_e, coef_f, output ready);
endinterface

interface ami_rsp_if;
   ami_pkg::word_type inv_a, inv_b, inv_c, inv_d, inv_e, inv_f;
   logic singular;
   logic overflow;
   logic valid;
   logic ready;
   modport source (output valid, inv_a, inv_b, inv_c, inv_d, inv_e, inv_f, singular,
                   overflow, input ready);
   modport sink (input valid, inv_a, inv_b, inv_c, inv_d, inv_e, inv_f, singular,
                 overflow, output ready);
endinterface

// ===== hdl/affine_matrix_inverse.sv =====
// Channel        | dir | payload
// req (sink)     | in  | coef_a..coef_f, signed fixed point
// rsp (source)   | out | inv_a..inv_f, singular, overflow
// csr            | in  | singular threshold write
// One matrix is taken every cycle while the response side is not stalled.
// Depth is set by the restoring divider, one quotient bit per stage (64 stages),
// plus product, determinant and divider load stages in front and quotient saturation,
// translation product and translation saturation stages behind.
// Reset (synchronous) clears valids. A stall freezes the whole pipeline in place (global enable).
module affine_matrix_inverse #(
   parameter int FRAC_BITS = 16,
   parameter int COEF_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [ami_pkg::THRESH_BITS-1:0] csr_write_data,
   ami_req_if.sink req,
   ami_rsp_if.source rsp
);
   import ami_pkg::*;
   localparam int PW = 2*COEF_BITS;        // product width
   localparam int QB = 64;                 // quotient bits
   localparam int RW = PW + 1;             // remainder width
   localparam int NS = QB + 6;             // stage count
   localparam logic [COEF_BITS:0] LIM = (COEF_BITS+1)'(1) << (COEF_BITS-1);

   logic [THRESH_BITS-1:0] thresh_ff;
   logic adv;
   logic [NS-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) thresh_ff <= '0;
      else if (csr_write_enable) thresh_ff <= csr_write_data;
   end

   assign adv = !vld_ff[NS-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NS-2:0], req.valid};
   end

   // stage 0: products
   logic signed [COEF_BITS-1:0] a0, b0, c0, d0, e0, f0;
   logic signed [PW-1:0] ad_ff, bc_ff;
   logic signed [COEF_BITS-1:0] a1_ff, b1_ff, c1_ff, d1_ff, e1_ff, f1_ff;
   assign a0 = req.coef_a[COEF_BITS-1:0];
   assign b0 = req.coef_b[COEF_BITS-1:0];
   assign c0 = req.coef_c[COEF_BITS-1:0];
   assign d0 = req.coef_d[COEF_BITS-1:0];
   assign e0 = req.coef_e[COEF_BITS-1:0];
   assign f0 = req.coef_f[COEF_BITS-1:0];
   always_ff @(posedge clock) begin
      if (adv) begin
         ad_ff <= PW'(a0) * PW'(d0);
         bc_ff <= PW'(b0) * PW'(c0);
         a1_ff <= a0; b1_ff <= b0; c1_ff <= c0; d1_ff <= d0; e1_ff <= e0; f1_ff <= f0;
      end
   end

   // stage 1: determinant magnitude, singular test, dividend magnitudes
   logic signed [PW:0] det1;
   logic [PW:0] dmag1;
   logic [PW:0] dmag2_ff;
   logic sing2_ff, dneg2_ff;
   logic [COEF_BITS-1:0] m2_ff [4];
   logic n2_ff [4];
   logic signed [COEF_BITS-1:0] e2_ff, f2_ff;
   logic signed [COEF_BITS-1:0] x1 [4];
   assign det1 = (PW+1)'(ad_ff) - (PW+1)'(bc_ff);
   assign dmag1 = det1[PW] ? -det1 : det1;
   assign x1[0] = d1_ff; assign x1[1] = b1_ff; assign x1[2] = c1_ff; assign x1[3] = a1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         dmag2_ff <= dmag1;
         dneg2_ff <= det1[PW];
         sing2_ff <= dmag1 <= (PW+1)'(thresh_ff);
         for (int k = 0; k < 4; k++) begin
            m2_ff[k] <= x1[k][COEF_BITS-1] ? COEF_BITS'(-x1[k]) : COEF_BITS'(x1[k]);
            n2_ff[k] <= x1[k][COEF_BITS-1] ^ det1[PW] ^ (k == 1 || k == 2);
         end
         e2_ff <= e1_ff; f2_ff <= f1_ff;
      end
   end

   // divider: dividend = mag << 2*FRAC_BITS as 128 bits; first the high-part check
   localparam int DB = 128;
   logic [DB-1:0] num2 [4];
   logic [QB-1:0] hi2 [4];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         num2[k] = DB'(m2_ff[k]) << (2*FRAC_BITS);
         hi2[k] = num2[k][DB-1:QB];
      end
   end

   // divider stages 0..QB-1
   logic [RW-1:0] rem_ff [QB+1][4];
   logic [QB-1:0] lo_ff [QB+1][4];
   logic [QB-1:0] q_ff [QB+1][4];
   logic big_ff [QB+1][4];
   logic [PW:0] dv_ff [QB+1];
   logic neg_ff [QB+1][4];
   logic sg_ff [QB+1];
   logic signed [COEF_BITS-1:0] ep_ff [QB+1], fp_ff [QB+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0] <= dmag2_ff; sg_ff[0] <= sing2_ff; ep_ff[0] <= e2_ff; fp_ff[0] <= f2_ff;
         for (int k = 0; k < 4; k++) begin
            rem_ff[0][k] <= RW'(hi2[k]);
            lo_ff[0][k] <= num2[k][QB-1:0];
            q_ff[0][k] <= '0;
            big_ff[0][k] <= (PW+1)'(hi2[k]) >= dmag2_ff;
            neg_ff[0][k] <= n2_ff[k];
         end
      end
   end

   for (genvar s = 0; s < QB; s++) begin : g_div
      logic [RW:0] r_sh [4];
      logic [RW:0] r_sub [4];
      always_comb begin
         for (int k = 0; k < 4; k++) begin
            r_sh[k] = {rem_ff[s][k], lo_ff[s][k][QB-1]};
            r_sub[k] = r_sh[k] - (RW+1)'(dv_ff[s]);
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[s+1] <= dv_ff[s]; sg_ff[s+1] <= sg_ff[s];
            ep_ff[s+1] <= ep_ff[s]; fp_ff[s+1] <= fp_ff[s];
            for (int k = 0; k < 4; k++) begin
               lo_ff[s+1][k] <= lo_ff[s][k] << 1;
               big_ff[s+1][k] <= big_ff[s][k];
               neg_ff[s+1][k] <= neg_ff[s][k];
               if (!r_sub[k][RW]) begin
                  rem_ff[s+1][k] <= r_sub[k][RW-1:0];
                  q_ff[s+1][k] <= {q_ff[s][k][QB-2:0], 1'b1};
               end else begin
                  rem_ff[s+1][k] <= r_sh[k][RW-1:0];
                  q_ff[s+1][k] <= {q_ff[s][k][QB-2:0], 1'b0};
               end
            end
         end
      end
   end

   // saturate quotients, select identity
   logic [QB-1:0] qm [4];
   logic signed [COEF_BITS-1:0] qs [4];
   logic qo [4];
   logic signed [COEF_BITS-1:0] one_v;
   logic one_o;
   always_comb begin
      one_o = (FRAC_BITS >= COEF_BITS-1);
      one_v = one_o ? {1'b0, {(COEF_BITS-1){1'b1}}} : COEF_BITS'(1) << FRAC_BITS;
      for (int k = 0; k < 4; k++) begin
         qm[k] = big_ff[QB][k] ? '1 : q_ff[QB][k];
         if (neg_ff[QB][k]) begin
            qo[k] = qm[k] > QB'(LIM);
            qs[k] = qo[k] ? {1'b1, {(COEF_BITS-1){1'b0}}} : COEF_BITS'(-qm[k]);
         end else begin
            qo[k] = qm[k] > QB'(LIM) - 1;
            qs[k] = qo[k] ? {1'b0, {(COEF_BITS-1){1'b1}}} : COEF_BITS'(qm[k]);
         end
      end
   end

   logic signed [COEF_BITS-1:0] r3_ff [4];
   logic o3_ff, s3_ff;
   logic signed [COEF_BITS-1:0] e3_ff, f3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff <= sg_ff[QB];
         e3_ff <= ep_ff[QB]; f3_ff <= fp_ff[QB];
         if (sg_ff[QB]) begin
            r3_ff[0] <= one_v; r3_ff[1] <= '0; r3_ff[2] <= '0; r3_ff[3] <= one_v;
            o3_ff <= one_o;
         end else begin
            for (int k = 0; k < 4; k++) r3_ff[k] <= qs[k];
            o3_ff <= qo[0] | qo[1] | qo[2] | qo[3];
         end
      end
   end

   // translation products
   logic signed [PW-1:0] p4_ff [4];
   logic signed [COEF_BITS-1:0] r4_ff [4];
   logic o4_ff, s4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         p4_ff[0] <= PW'(e3_ff) * PW'(r3_ff[0]);
         p4_ff[1] <= PW'(f3_ff) * PW'(r3_ff[2]);
         p4_ff[2] <= PW'(e3_ff) * PW'(r3_ff[1]);
         p4_ff[3] <= PW'(f3_ff) * PW'(r3_ff[3]);
         r4_ff <= r3_ff; o4_ff <= o3_ff; s4_ff <= s3_ff;
      end
   end

   // difference, shift, saturate
   logic signed [PW+1:0] t5 [2];
   logic [PW+1:0] tm5 [2];
   logic [PW+1:0] ts5 [2];
   logic signed [COEF_BITS-1:0] tr5 [2];
   logic to5 [2];
   always_comb begin
      t5[0] = -(PW+2)'(p4_ff[0]) - (PW+2)'(p4_ff[1]);
      t5[1] = -(PW+2)'(p4_ff[2]) - (PW+2)'(p4_ff[3]);
      for (int k = 0; k < 2; k++) begin
         tm5[k] = t5[k][PW+1] ? -t5[k] : t5[k];
         ts5[k] = tm5[k] >> FRAC_BITS;
         if (t5[k][PW+1]) begin
            to5[k] = ts5[k] > (PW+2)'(LIM);
            tr5[k] = to5[k] ? {1'b1, {(COEF_BITS-1){1'b0}}} : COEF_BITS'(-ts5[k]);
         end else begin
            to5[k] = ts5[k] > (PW+2)'(LIM) - 1;
            tr5[k] = to5[k] ? {1'b0, {(COEF_BITS-1){1'b1}}} : COEF_BITS'(ts5[k]);
         end
         if (s4_ff) begin
            to5[k] = 1'b0;
            tr5[k] = '0;
         end
      end
   end

   logic signed [COEF_BITS-1:0] out_ff [6];
   logic so_ff, oo_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) out_ff[k] <= r4_ff[k];
         out_ff[4] <= tr5[0]; out_ff[5] <= tr5[1];
         so_ff <= s4_ff; oo_ff <= o4_ff | to5[0] | to5[1];
      end
   end

   assign rsp.valid = vld_ff[NS-1];
   assign rsp.inv_a = PORT_BITS'($unsigned(out_ff[0]));
   assign rsp.inv_b = PORT_BITS'($unsigned(out_ff[1]));
   assign rsp.inv_c = PORT_BITS'($unsigned(out_ff[2]));
   assign rsp.inv_d = PORT_BITS'($unsigned(out_ff[3]));
   assign rsp.inv_e = PORT_BITS'($unsigned(out_ff[4]));
   assign rsp.inv_f = PORT_BITS'($unsigned(out_ff[5]));
   assign rsp.singular = so_ff;
   assign rsp.overflow = oo_ff;
endmodule

// ===== hdl/ami_checker.sv =====
// Port-level checks for affine_matrix_inverse, attached by bind.
// Depends on the top level's ports only.
module ami_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic req_ready,
   input logic rsp_singular,
   input logic [31:0] rsp_inv_b,
   input logic [31:0] rsp_inv_e
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("ready low with empty output");
   a_sing_b: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_inv_b == '0) else $error("singular b");
   a_sing_e: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_inv_e == '0) else $error("singular e");
endmodule

bind affine_matrix_inverse ami_checker u_ami_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .req_ready(req.ready), .rsp_singular(rsp.singular), .rsp_inv_b(rsp.inv_b),
   .rsp_inv_e(rsp.inv_e)
);
